### rtl/core/wsdm_pkg.sv
// ----------------------------------------------------------------------------
// wsdm_pkg
// Shared types and constants of the wildcard star/dot matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int SYMBOL_W        = 8;
  localparam int REQ_W           = 2;
  localparam int COUNT_W         = 16;

  localparam logic [SYMBOL_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [SYMBOL_W-1:0] DOT_BYTE  = 8'h2E;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = 16'hFFFF;

  // request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_START  = 2'd2,
    REQ_BYTE   = 2'd3
  } req_type_e;

  // operation applied to every cell in one cycle
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2,
    OP_CLOSE   = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [SYMBOL_W-1:0] symbol;
    logic                wr_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/wsdm_if.sv
// ----------------------------------------------------------------------------
// wsdm_if
// Valid/ready channels of the matcher: request words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsdm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] symbol;

  modport source (output valid, req_type, symbol, input ready);
  modport sink   (input valid, req_type, symbol, output ready);
endinterface

interface wsdm_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [15:0] subject_length;
  logic        status;

  modport source (output valid, matched, subject_length, status, input ready);
  modport sink   (input valid, matched, subject_length, status, output ready);
endinterface

`default_nettype wire

### rtl/core/wsdm_cell.sv
// ----------------------------------------------------------------------------
// wsdm_cell
// One pattern position: holds its pattern byte and its match bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wsdm_cell
  import wsdm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int INDEX       = 1,
  localparam int LW         = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cell_ctrl_t          ctrl,
  input  wire logic [LW-1:0]       length,
  input  wire logic [SYMBOL_W-1:0] prev_byte,   // pattern byte of left neighbor
  input  wire logic                prev_bit,    // match bit one position left
  input  wire logic                skip_bit,    // match bit two positions left
  output logic [SYMBOL_W-1:0]      pat_byte,
  output logic                     match_bit,
  output logic                     grow
);

  localparam bit HAS_PREV = (INDEX >= 2);

  logic active;
  logic is_star;
  logic lit_hit;
  logic prev_hit;
  logic step_bit;
  logic close_hit;

  assign active    = (LW'(INDEX) <= length);
  assign is_star   = (pat_byte == STAR_BYTE);
  assign lit_hit   = (pat_byte == DOT_BYTE) || (pat_byte == ctrl.symbol);
  assign prev_hit  = (prev_byte == DOT_BYTE) || (prev_byte == ctrl.symbol);
  // leading star never matches; star repeats the element to its left
  assign step_bit  = active && (is_star ? (HAS_PREV && prev_hit && match_bit)
                                        : (lit_hit && prev_bit));
  // zero repetitions: star position inherits the bit two places left
  assign close_hit = active && is_star && HAS_PREV && skip_bit;
  assign grow      = (ctrl.op == OP_CLOSE) && close_hit && !match_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_RESTART: match_bit <= 1'b0;
        OP_STEP:    match_bit <= step_bit;
        OP_CLOSE:   match_bit <= match_bit | close_hit;
        default:    match_bit <= match_bit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (length == LW'(INDEX - 1))) begin
      pat_byte <= ctrl.symbol;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wildcard_star_dot_matcher_core.sv
// Flow: accept cycle in S_IDLE, then closure passes in S_CLOSE until a pass
//   sets no new bit, then S_DONE loads the result register once the last
//   result is taken. Words are accepted only in S_IDLE, so a new word waits
//   until the last one is through its closure passes. A new word is taken
//   while the last result waits.
// Reset (rst, sync): pattern empty, row holds only the empty-prefix bit, count zero.
// ----------------------------------------------------------------------------
// wildcard_star_dot_matcher_core
// Whole-string matcher for literal, '.' and 'x*' patterns built as a row of
// cells, one per pattern position, each updating its match bit per word.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_star_dot_matcher_core
  import wsdm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  wsdm_in_if.sink    req,
  wsdm_out_if.source rsp
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_DONE
  } state_t;

  state_t              state;
  logic [LW-1:0]       length;          // pattern bytes stored
  logic                row0;            // empty-pattern-prefix bit
  logic [COUNT_W-1:0]  count;           // subject bytes since start
  logic                status_q;        // dropped append of current word

  logic                rsp_valid;
  logic                rsp_matched;
  logic [COUNT_W-1:0]  rsp_length;
  logic                rsp_status;

  cell_ctrl_t          ctrl;
  logic                accept;
  logic                full;
  logic [MAX_PATTERN:0]   row_bits;
  logic [SYMBOL_W-1:0]    bytes [1:MAX_PATTERN];
  logic [MAX_PATTERN:1]   grow;
  logic                   grow_any;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (length == LW'(MAX_PATTERN));
  assign grow_any  = |grow;
  assign row_bits[0] = row0;

  // Cell control: one op per cycle, broadcast along the row.
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.symbol = req.symbol;
    ctrl.wr_en  = 1'b0;
    if (accept) begin
      case (req.req_type)
        REQ_CLEAR:  ctrl.op = OP_RESTART;
        REQ_APPEND: begin
          if (!full) begin
            ctrl.wr_en = 1'b1;
            ctrl.op    = OP_RESTART;
          end
        end
        REQ_START:  ctrl.op = OP_RESTART;
        REQ_BYTE:   ctrl.op = OP_STEP;
        default:    ctrl.op = OP_HOLD;
      endcase
    end else if (state == S_CLOSE) begin
      ctrl.op = OP_CLOSE;
    end
  end

  // Row of cells; cell j covers pattern position j (byte j-1).
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic [SYMBOL_W-1:0] prev_byte;
    logic                skip_bit;
    if (j >= 2) begin : g_mid
      assign prev_byte = bytes[j-1];
      assign skip_bit  = row_bits[j-2];
    end else begin : g_first
      assign prev_byte = '0;
      assign skip_bit  = 1'b0;
    end

    wsdm_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .INDEX       (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .length    (length),
      .prev_byte (prev_byte),
      .prev_bit  (row_bits[j-1]),
      .skip_bit  (skip_bit),
      .pat_byte  (bytes[j]),
      .match_bit (row_bits[j]),
      .grow      (grow[j])
    );
  end

  // Sequencer plus result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      length     <= '0;
      row0       <= 1'b1;
      count      <= '0;
      status_q   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_q <= 1'b0;
            case (req.req_type)
              REQ_CLEAR: begin
                length <= '0;
                row0   <= 1'b1;
                count  <= '0;
              end
              REQ_APPEND: begin
                if (full) begin
                  status_q <= 1'b1;       // byte dropped, state untouched
                end else begin
                  length <= length + LW'(1);
                  row0   <= 1'b1;
                  count  <= '0;
                end
              end
              REQ_START: begin
                row0  <= 1'b1;
                count <= '0;
              end
              REQ_BYTE: begin
                row0 <= 1'b0;             // empty prefix cannot cover a byte
                if (count != COUNT_MAX) begin
                  count <= count + COUNT_W'(1);
                end
              end
              default: begin
              end
            endcase
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          // stop once a pass sets no new bit
          if (!grow_any) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            rsp_matched <= row_bits[length];
            rsp_length  <= count;
            rsp_status  <= status_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.matched        = rsp_matched;
  assign rsp.subject_length = rsp_length;
  assign rsp.status         = rsp_status;

endmodule

`default_nettype wire
